// File: src/mrmp_pkg.sv
`timescale 1ns / 1ps
package mrmp_pkg;

    localparam int unsigned CountW    = 17;
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [7:0]  PrintLow  = 8'h20;
    localparam logic [7:0]  PrintHigh = 8'h7E;
    localparam logic [15:0] MaxIdReset = 16'd64;
    localparam int unsigned QDepth    = 2;
    localparam int unsigned QAddrW    = $clog2(QDepth);
    localparam int unsigned QCountW   = $clog2(QDepth + 1);

    typedef enum logic [2:0] {
        V_OK         = 3'd0,
        V_SHORT      = 3'd1,
        V_BAD_OP     = 3'd2,
        V_BODY_LEN   = 3'd3,
        V_ID_LEN     = 3'd4,
        V_BAD_ID     = 3'd5,
        V_BAD_STATUS = 3'd6,
        V_MISMATCH   = 3'd7
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  id_char;
        logic [2:0]  verdict_code;
        logic [2:0]  op_code;
        logic [31:0] retry_after_ms;
        logic [15:0] id_length;
    } t_out;

    // work handed from the byte front to the verdict back
    typedef struct packed {
        logic              is_verdict;
        logic [7:0]        id_char;
        logic [CountW-1:0] size;
        logic [15:0]       op_word;
        logic [15:0]       body_length;
        logic [15:0]       ident_length;
        logic [15:0]       status_word;
        logic [31:0]       retry_word;
        logic              ident_bad;
    } t_job;

endpackage

// File: src/meta_response_message_parser_core.sv
`timescale 1ns / 1ps
// Path: a byte that yields a result is queued, then judged and put on o_data.
// Throughput: one byte per cycle while the queue has space; the front
//   classifies and captures a byte in its accept cycle, the back judges and
//   registers one result per cycle while the output is not stalled.
// Reset: synchronous, active low; clears message state, queue pointers and
//   output valid, and sets max_id_length to 64.
module meta_response_message_parser_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mrmp_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output mrmp_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data
);
    import mrmp_pkg::*;

    logic [15:0] r_max_id;
    logic        push;
    logic        space;
    logic        pop;
    logic        avail;
    t_job        front_job;
    t_job        back_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id <= MaxIdReset;
        end else if (i_cfg_we) begin
            r_max_id <= i_cfg_data;
        end
    end

    mrmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_space (space),
        .o_ready (o_ready),
        .o_push  (push),
        .o_job   (front_job)
    );

    mrmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_space (space),
        .i_pop   (pop),
        .o_avail (avail),
        .o_job   (back_job)
    );

    mrmp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_max_id (r_max_id),
        .i_avail  (avail),
        .i_job    (back_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule

// File: src/mrmp_front.sv
`timescale 1ns / 1ps
module mrmp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mrmp_pkg::t_in   i_data,
    input  logic            i_space,
    output logic            o_ready,
    output logic            o_push,
    output mrmp_pkg::t_job  o_job
);
    import mrmp_pkg::*;

    logic [CountW-1:0] r_count, n_count;
    logic [15:0]       r_op, n_op;
    logic [15:0]       r_body, n_body;
    logic [15:0]       r_idlen, n_idlen;
    logic [15:0]       r_status, n_status;
    logic [31:0]       r_retry, n_retry;
    logic              r_bad, n_bad;
    logic [CountW-1:0] id_end;
    logic              in_id;
    logic              accept;
    logic [7:0]        b;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign b       = i_data.data_byte;
    assign id_end  = CountW'(6) + {1'b0, r_idlen};

    always_comb begin
        n_op     = r_op;
        n_body   = r_body;
        n_idlen  = r_idlen;
        n_status = r_status;
        n_retry  = r_retry;
        n_bad    = r_bad;
        in_id    = 1'b0;
        if (r_count < CountW'(2)) begin
            n_op = {r_op[7:0], b};
        end else if (r_count < CountW'(4)) begin
            n_body = {r_body[7:0], b};
        end else if (r_count < CountW'(6)) begin
            n_idlen = {r_idlen[7:0], b};
        end else if (r_count < id_end) begin
            in_id = 1'b1;
            if (b < PrintLow || b > PrintHigh) begin
                n_bad = 1'b1;
            end
        end else if (r_count < id_end + CountW'(2)) begin
            n_status = {r_status[7:0], b};
        end else if (r_count < id_end + CountW'(6)) begin
            n_retry = {r_retry[23:0], b};
        end
        n_count = (r_count == CountMax) ? r_count : r_count + CountW'(1);
    end

    assign o_push = accept && (i_data.last_byte || in_id);

    always_comb begin
        o_job.is_verdict   = i_data.last_byte;
        o_job.id_char      = b;
        o_job.size         = n_count;
        o_job.op_word      = n_op;
        o_job.body_length  = n_body;
        o_job.ident_length = n_idlen;
        o_job.status_word  = n_status;
        o_job.retry_word   = n_retry;
        o_job.ident_bad    = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_op     <= '0;
            r_body   <= '0;
            r_idlen  <= '0;
            r_status <= '0;
            r_retry  <= '0;
            r_bad    <= 1'b0;
        end else if (accept) begin
            if (i_data.last_byte) begin
                r_count  <= '0;
                r_op     <= '0;
                r_body   <= '0;
                r_idlen  <= '0;
                r_status <= '0;
                r_retry  <= '0;
                r_bad    <= 1'b0;
            end else begin
                r_count  <= n_count;
                r_op     <= n_op;
                r_body   <= n_body;
                r_idlen  <= n_idlen;
                r_status <= n_status;
                r_retry  <= n_retry;
                r_bad    <= n_bad;
            end
        end
    end

endmodule

// File: src/mrmp_queue.sv
`timescale 1ns / 1ps
module mrmp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrmp_pkg::t_job  i_job,
    output logic            o_space,
    input  logic            i_pop,
    output logic            o_avail,
    output mrmp_pkg::t_job  o_job
);
    import mrmp_pkg::*;

    t_job               r_mem [QDepth];
    logic [QAddrW-1:0]  r_wptr;
    logic [QAddrW-1:0]  r_rptr;
    logic [QCountW-1:0] r_fill;
    logic               do_pop;

    assign o_space = (r_fill != QCountW'(QDepth));
    assign o_avail = (r_fill != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QAddrW'(QDepth - 1)) ? '0 : r_wptr + QAddrW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QAddrW'(QDepth - 1)) ? '0 : r_rptr + QAddrW'(1);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + QCountW'(1);
            end else if (!i_push && do_pop) begin
                r_fill <= r_fill - QCountW'(1);
            end
        end
    end

endmodule

// File: src/mrmp_back.sv
`timescale 1ns / 1ps
module mrmp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_max_id,
    input  logic            i_avail,
    input  mrmp_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output mrmp_pkg::t_out  o_data
);
    import mrmp_pkg::*;

    logic     r_valid;
    t_out     r_out;
    t_out     n_out;
    t_verdict verdict;
    logic     load;

    // first failing check wins
    always_comb begin
        if (i_job.size < CountW'(12)) begin
            verdict = V_SHORT;
        end else if (i_job.op_word < 16'd1 || i_job.op_word > 16'd4) begin
            verdict = V_BAD_OP;
        end else if ({1'b0, i_job.body_length} + CountW'(4) != i_job.size
                     || i_job.body_length < 16'd8) begin
            verdict = V_BODY_LEN;
        end else if ({1'b0, i_job.ident_length} + CountW'(8) != {1'b0, i_job.body_length}) begin
            verdict = V_ID_LEN;
        end else if (i_job.ident_length == 16'd0 || i_job.ident_length > i_max_id
                     || i_job.ident_bad) begin
            verdict = V_BAD_ID;
        end else if (i_job.status_word < 16'd1 || i_job.status_word > 16'd4) begin
            verdict = V_BAD_STATUS;
        end else if (i_job.status_word != i_job.op_word) begin
            verdict = V_MISMATCH;
        end else begin
            verdict = V_OK;
        end
    end

    always_comb begin
        n_out = '0;
        if (i_job.is_verdict) begin
            n_out.kind         = 1'b1;
            n_out.verdict_code = verdict;
            if (verdict == V_OK) begin
                n_out.op_code        = i_job.op_word[2:0];
                n_out.retry_after_ms = i_job.retry_word;
                n_out.id_length      = i_job.ident_length;
            end
        end else begin
            n_out.id_char = i_job.id_char;
        end
    end

    assign load    = i_avail && (!r_valid || i_ready);
    assign o_pop   = load;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// File: src/mrmp_checker.sv
`timescale 1ns / 1ps
module mrmp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_ready,
    input  mrmp_pkg::t_in   i_data,
    input  logic            o_valid,
    input  logic            i_ready,
    input  mrmp_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data
);
    import mrmp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result changed while stalled");

    // pass-through bytes carry nothing but the byte
    a_id_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.kind |-> o_data.verdict_code == V_OK && o_data.op_code == 3'd0
            && o_data.retry_after_ms == 32'd0 && o_data.id_length == 16'd0)
        else $error("id byte result has verdict fields set");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind && o_data.verdict_code != V_OK |-> o_data.op_code == 3'd0
            && o_data.retry_after_ms == 32'd0 && o_data.id_length == 16'd0
            && o_data.id_char == 8'd0)
        else $error("failed verdict carries data");

    a_ok_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind && o_data.verdict_code == V_OK |-> o_data.op_code != 3'd0
            && o_data.op_code <= 3'd4 && o_data.id_length != 16'd0)
        else $error("ok verdict with bad op or id length");

endmodule

bind meta_response_message_parser_core mrmp_checker u_mrmp_checker (.*);
